FILE: src/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers for the unit normal block
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: implication");

`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next cycle");

`else

`define ASSERT_IMPLY(label, clk, rst_n, ante, cons)

`define ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

FILE: src/tun_pkg.sv
// ----------------------------------------------------------------------------
// tun_pkg
// Shared types for the triangle unit normal block
// ----------------------------------------------------------------------------
package tun_pkg;

    typedef struct packed {
        logic valid;
        logic neg;
    } t_tag;

endpackage

FILE: src/tun_front.sv
// ----------------------------------------------------------------------------
// tun_front
// Edge vectors, cross product, component squares and squared length
// ----------------------------------------------------------------------------
module tun_front
    import tun_pkg::*;
#(
    parameter int COORD_WIDTH = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_en,
    input  logic                              i_valid,
    input  logic signed [COORD_WIDTH-1:0]     i_p [9],
    output logic                              o_valid,
    output logic [2*(2*COORD_WIDTH+1)-1:0]    o_nsq [3],
    output logic [2*(2*COORD_WIDTH+1)+1:0]    o_sq,
    output logic                              o_neg [3]
);

    localparam int C  = COORD_WIDTH;
    localparam int MW = 2*C + 1;
    localparam int H  = (MW + 1) / 2;
    localparam int HW = MW - H;
    localparam int NW = 2*MW;
    localparam int SW = NW + 2;

    logic                r_v1, r_v2, r_v3, r_v4, r_v5, r_v6;
    logic signed [C:0]   r_a [3];
    logic signed [C:0]   r_b [3];
    logic signed [2*C+1:0] r_pr [6];
    logic [MW-1:0]       r_mag [3];
    logic                r_neg3 [3];
    logic                r_neg4 [3];
    logic                r_neg5 [3];
    logic                r_neg6 [3];
    logic [2*HW-1:0]     r_hh [3];
    logic [MW-1:0]       r_hl [3];
    logic [2*H-1:0]      r_ll [3];
    logic [NW-1:0]       r_nsq5 [3];
    logic [NW-1:0]       r_nsq6 [3];
    logic [SW-1:0]       r_sq;
    logic [SW-1:0]       w_sum;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
            r_v6 <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
            r_v5 <= r_v4;
            r_v6 <= r_v5;
        end
    end

    assign w_sum = SW'(r_nsq5[0]) + SW'(r_nsq5[1]) + SW'(r_nsq5[2]);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < 3; k++) begin
                r_a[k] <= $signed({i_p[k][C-1], i_p[k]}) - $signed({i_p[k+3][C-1], i_p[k+3]});
                r_b[k] <= $signed({i_p[k+3][C-1], i_p[k+3]})
                        - $signed({i_p[k+6][C-1], i_p[k+6]});
            end
            r_pr[0] <= r_a[1] * r_b[2];
            r_pr[1] <= r_a[2] * r_b[1];
            r_pr[2] <= r_a[2] * r_b[0];
            r_pr[3] <= r_a[0] * r_b[2];
            r_pr[4] <= r_a[0] * r_b[1];
            r_pr[5] <= r_a[1] * r_b[0];
            for (int k = 0; k < 3; k++) begin
                logic signed [2*C+1:0] n;
                n = r_pr[2*k] - r_pr[2*k+1];
                r_neg3[k] <= n[2*C+1];
                r_mag[k]  <= n[2*C+1] ? MW'(-n) : MW'(n);
                r_hh[k]   <= r_mag[k][MW-1:H] * r_mag[k][MW-1:H];
                r_hl[k]   <= MW'(r_mag[k][MW-1:H] * r_mag[k][H-1:0]);
                r_ll[k]   <= r_mag[k][H-1:0] * r_mag[k][H-1:0];
                r_neg4[k] <= r_neg3[k];
                r_nsq5[k] <= (NW'(r_hh[k]) << (2*H)) + (NW'(r_hl[k]) << (H+1))
                           + NW'(r_ll[k]);
                r_neg5[k] <= r_neg4[k];
                r_nsq6[k] <= r_nsq5[k];
                r_neg6[k] <= r_neg5[k];
            end
            r_sq <= (w_sum == '0) ? SW'(1) : w_sum;
        end
    end

    assign o_valid = r_v6;
    assign o_sq    = r_sq;
    assign o_nsq   = r_nsq6;
    assign o_neg   = r_neg6;

endmodule

FILE: src/tun_lane.sv
// ----------------------------------------------------------------------------
// tun_lane
// One normal component: restoring divide, integer square root, rounding
// ----------------------------------------------------------------------------
module tun_lane
    import tun_pkg::*;
#(
    parameter int COORD_WIDTH      = 16,
    parameter int NORMAL_FRAC_BITS = 14
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_en,
    input  t_tag                                i_tag,
    input  logic [2*(2*COORD_WIDTH+1)-1:0]      i_nsq,
    input  logic [2*(2*COORD_WIDTH+1)+1:0]      i_sq,
    output t_tag                                o_tag,
    output logic signed [NORMAL_FRAC_BITS+1:0]  o_val
);

    localparam int F  = NORMAL_FRAC_BITS;
    localparam int NW = 2*(2*COORD_WIDTH+1);
    localparam int SW = NW + 2;
    localparam int QW = 2*F + 3;
    localparam int MB = F + 2;
    localparam int OW = F + 2;

    logic [SW-1:0] r_rem  [QW];
    logic [SW-1:0] r_div  [QW];
    logic [QW-1:0] r_quo  [QW];
    t_tag          r_dtag [QW];
    logic [QW-1:0] r_srem [MB];
    logic [MB-1:0] r_root [MB];
    t_tag          r_stag [MB];
    t_tag          r_otag;
    logic signed [OW-1:0] r_val;

    for (genvar j = 0; j < QW; j++) begin : g_div
        logic [SW-1:0] w_rin;
        logic [SW-1:0] w_din;
        logic [QW-1:0] w_qin;
        t_tag          w_tin;
        logic          w_bit;
        logic [SW:0]   w_t;
        logic [SW:0]   w_d;
        if (j == 0) begin : g_first
            assign w_rin = SW'(i_nsq >> 1);
            assign w_din = i_sq;
            assign w_qin = '0;
            assign w_tin = i_tag;
            assign w_bit = i_nsq[0];
        end else begin : g_rest
            assign w_rin = r_rem[j-1];
            assign w_din = r_div[j-1];
            assign w_qin = r_quo[j-1];
            assign w_tin = r_dtag[j-1];
            assign w_bit = 1'b0;
        end
        assign w_t = {w_rin, w_bit};
        assign w_d = {1'b0, w_din};
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dtag[j].valid <= 1'b0;
            end else if (i_en) begin
                r_dtag[j].valid <= w_tin.valid;
            end
        end
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_dtag[j].neg <= w_tin.neg;
                r_div[j]      <= w_din;
                if (w_t >= w_d) begin
                    r_rem[j] <= SW'(w_t - w_d);
                    r_quo[j] <= {w_qin[QW-2:0], 1'b1};
                end else begin
                    r_rem[j] <= SW'(w_t);
                    r_quo[j] <= {w_qin[QW-2:0], 1'b0};
                end
            end
        end
    end

    for (genvar i = 0; i < MB; i++) begin : g_sqrt
        localparam int K = MB - 1 - i;
        logic [QW-1:0]  w_rin;
        logic [MB-1:0]  w_root;
        t_tag           w_tin;
        logic [QW+1:0]  w_trial;
        if (i == 0) begin : g_first
            assign w_rin  = r_quo[QW-1];
            assign w_root = '0;
            assign w_tin  = r_dtag[QW-1];
        end else begin : g_rest
            assign w_rin  = r_srem[i-1];
            assign w_root = r_root[i-1];
            assign w_tin  = r_stag[i-1];
        end
        assign w_trial = ((QW+2)'(w_root) << (K+1)) | ((QW+2)'(1) << (2*K));
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_stag[i].valid <= 1'b0;
            end else if (i_en) begin
                r_stag[i].valid <= w_tin.valid;
            end
        end
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_stag[i].neg <= w_tin.neg;
                if ((QW+2)'(w_rin) >= w_trial) begin
                    r_srem[i] <= QW'((QW+2)'(w_rin) - w_trial);
                    r_root[i] <= w_root | (MB'(1) << K);
                end else begin
                    r_srem[i] <= w_rin;
                    r_root[i] <= w_root;
                end
            end
        end
    end

    logic [MB:0]   w_inc;
    logic [F:0]    w_q;

    assign w_inc = (MB+1)'(r_root[MB-1]) + (MB+1)'(1);
    assign w_q   = w_inc[F+1:1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_otag.valid <= 1'b0;
        end else if (i_en) begin
            r_otag.valid <= r_stag[MB-1].valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_otag.neg <= r_stag[MB-1].neg;
            r_val      <= r_stag[MB-1].neg ? -$signed(OW'(w_q)) : $signed(OW'(w_q));
        end
    end

    assign o_tag = r_otag;
    assign o_val = r_val;

endmodule

FILE: src/tun_merge.sv
// ----------------------------------------------------------------------------
// tun_merge
// Joins the three lanes, flags a zero normal, output register and skid stage
// ----------------------------------------------------------------------------
module tun_merge
    import tun_pkg::*;
#(
    parameter int NORMAL_FRAC_BITS = 14
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  t_tag                                i_tag,
    input  logic signed [NORMAL_FRAC_BITS+1:0]  i_x,
    input  logic signed [NORMAL_FRAC_BITS+1:0]  i_y,
    input  logic signed [NORMAL_FRAC_BITS+1:0]  i_z,
    input  logic                                i_stall,
    output logic                                o_en,
    output logic                                o_valid,
    output logic signed [NORMAL_FRAC_BITS+1:0]  o_x,
    output logic signed [NORMAL_FRAC_BITS+1:0]  o_y,
    output logic signed [NORMAL_FRAC_BITS+1:0]  o_z,
    output logic                                o_degenerate
);

    localparam int OW = NORMAL_FRAC_BITS + 2;
    localparam int DW = 3*OW + 1;

    logic          r_out_v, n_out_v;
    logic          r_skid_v, n_skid_v;
    logic [DW-1:0] r_out_d, n_out_d;
    logic [DW-1:0] r_skid_d, n_skid_d;
    logic [DW-1:0] w_beat;
    logic          w_in;
    logic          w_free;

    assign w_beat = {i_x, i_y, i_z, (i_x == '0) && (i_y == '0) && (i_z == '0)};
    assign o_en   = !r_skid_v;
    assign w_in   = o_en && i_tag.valid;
    assign w_free = !r_out_v || !i_stall;

    always_comb begin
        n_out_v  = r_out_v;
        n_out_d  = r_out_d;
        n_skid_v = r_skid_v;
        n_skid_d = r_skid_d;
        if (w_free) begin
            if (r_skid_v) begin
                n_out_v  = 1'b1;
                n_out_d  = r_skid_d;
                n_skid_v = 1'b0;
            end else begin
                n_out_v = w_in;
                n_out_d = w_beat;
            end
        end else if (w_in) begin
            n_skid_v = 1'b1;
            n_skid_d = w_beat;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else begin
            r_out_v  <= n_out_v;
            r_skid_v <= n_skid_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_d  <= n_out_d;
        r_skid_d <= n_skid_d;
    end

    assign o_valid      = r_out_v;
    assign o_x          = r_out_d[DW-1 -: OW];
    assign o_y          = r_out_d[DW-1-OW -: OW];
    assign o_z          = r_out_d[OW:1];
    assign o_degenerate = r_out_d[0];

endmodule

FILE: src/triangle_unit_normal.sv
// ----------------------------------------------------------------------------
// triangle_unit_normal
// Unit surface normal of a triangle, signed Q1.14, exactly rounded
// ----------------------------------------------------------------------------
// channel   direction  handshake           payload
// vertices  in         i_valid / o_stall   i_p{0,1,2}_{x,y,z}
// normal    out        o_valid / i_stall   o_normal_{x,y,z}, o_degenerate
//
// one triangle per cycle while o_stall is low; the divider and square root in each
// lane resolve one bit per stage
// reset clears all valid flags; no clearing pass
// a stalled result waits in the output register while the skid stage takes
// one more; the pipeline holds only while the skid stage is full
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module triangle_unit_normal
    import tun_pkg::*;
#(
    parameter int COORD_WIDTH      = 16,
    parameter int NORMAL_FRAC_BITS = 14
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic signed [COORD_WIDTH-1:0]       i_p0_x,
    input  logic signed [COORD_WIDTH-1:0]       i_p0_y,
    input  logic signed [COORD_WIDTH-1:0]       i_p0_z,
    input  logic signed [COORD_WIDTH-1:0]       i_p1_x,
    input  logic signed [COORD_WIDTH-1:0]       i_p1_y,
    input  logic signed [COORD_WIDTH-1:0]       i_p1_z,
    input  logic signed [COORD_WIDTH-1:0]       i_p2_x,
    input  logic signed [COORD_WIDTH-1:0]       i_p2_y,
    input  logic signed [COORD_WIDTH-1:0]       i_p2_z,
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic signed [NORMAL_FRAC_BITS+1:0]  o_normal_x,
    output logic signed [NORMAL_FRAC_BITS+1:0]  o_normal_y,
    output logic signed [NORMAL_FRAC_BITS+1:0]  o_normal_z,
    output logic                                o_degenerate
);

    localparam int NW = 2*(2*COORD_WIDTH+1);
    localparam int SW = NW + 2;
    localparam int OW = NORMAL_FRAC_BITS + 2;
    localparam logic signed [OW-1:0] ONE = OW'(1) << NORMAL_FRAC_BITS;

    logic                 w_en;
    logic signed [COORD_WIDTH-1:0] w_p [9];
    logic                 w_fvalid;
    logic [NW-1:0]        w_nsq [3];
    logic [SW-1:0]        w_sq;
    logic                 w_neg [3];
    t_tag                 w_tag [3];
    logic signed [OW-1:0] w_val [3];

    assign w_p[0] = i_p0_x;
    assign w_p[1] = i_p0_y;
    assign w_p[2] = i_p0_z;
    assign w_p[3] = i_p1_x;
    assign w_p[4] = i_p1_y;
    assign w_p[5] = i_p1_z;
    assign w_p[6] = i_p2_x;
    assign w_p[7] = i_p2_y;
    assign w_p[8] = i_p2_z;

    assign o_stall = !w_en;

    tun_front #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (i_valid),
        .i_p     (w_p),
        .o_valid (w_fvalid),
        .o_nsq   (w_nsq),
        .o_sq    (w_sq),
        .o_neg   (w_neg)
    );

    for (genvar k = 0; k < 3; k++) begin : g_lane
        tun_lane #(
            .COORD_WIDTH      (COORD_WIDTH),
            .NORMAL_FRAC_BITS (NORMAL_FRAC_BITS)
        ) u_lane (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_tag   ('{valid: w_fvalid, neg: w_neg[k]}),
            .i_nsq   (w_nsq[k]),
            .i_sq    (w_sq),
            .o_tag   (w_tag[k]),
            .o_val   (w_val[k])
        );
    end

    tun_merge #(
        .NORMAL_FRAC_BITS (NORMAL_FRAC_BITS)
    ) u_merge (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_tag        (w_tag[0]),
        .i_x          (w_val[0]),
        .i_y          (w_val[1]),
        .i_z          (w_val[2]),
        .i_stall      (i_stall),
        .o_en         (w_en),
        .o_valid      (o_valid),
        .o_x          (o_normal_x),
        .o_y          (o_normal_y),
        .o_z          (o_normal_z),
        .o_degenerate (o_degenerate)
    );

    // lanes run in lockstep
    `ASSERT_IMPLY(a_lane_sync, i_clk, i_rst_n, w_tag[0].valid, w_tag[1].valid && w_tag[2].valid)
    // skid stage only fills behind a waiting result
    `ASSERT_IMPLY(a_skid_behind_out, i_clk, i_rst_n, o_stall, o_valid)
    // degenerate beat carries a zero vector
    `ASSERT_IMPLY(a_degen_zero, i_clk, i_rst_n, o_valid && o_degenerate, o_normal_x == '0 && o_normal_y == '0 && o_normal_z == '0)
    // components stay within plus or minus one
    `ASSERT_IMPLY(a_unit_range, i_clk, i_rst_n, o_valid, o_normal_x <= ONE && o_normal_x >= -ONE && o_normal_y <= ONE && o_normal_y >= -ONE && o_normal_z <= ONE && o_normal_z >= -ONE)

endmodule
